// File: rtl/core/hff_pkg.sv
// hff_pkg: shared types and character constants of the hex float formatter
`timescale 1ns / 1ps

package hff_pkg;

  // width of a fraction digit count, settled by the 7-bit precision field
  localparam int FRAC_CNT_W = 6;
  localparam int QUEUE_DEPTH = 2;

  // ascii characters
  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_P     = 7'h70;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_I     = 7'h69;
  localparam logic [6:0] CH_F     = 7'h66;
  localparam logic [6:0] CH_UC_A  = 7'h41;
  // bit that separates lower from upper case letters
  localparam logic [6:0] CH_CASE  = 7'h20;

  typedef enum logic [1:0] {
    K_NUM,
    K_INF,
    K_NAN
  } fmt_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLASS,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_WORD,
    B_SIGN,
    B_ZERO,
    B_X,
    B_LEAD,
    B_POINT,
    B_FRAC,
    B_PEXP,
    B_ESIGN,
    B_EDIG
  } back_state_t;

  // one classified value, ready to be spelled out
  typedef struct packed {
    fmt_kind_t             kind;
    logic                  has_sign;
    logic [6:0]            sign_ch;
    logic                  upper;
    logic [1:0]            lead;
    logic                  point;
    logic [FRAC_CNT_W-1:0] nfrac;
    logic [63:0]           frac;
    logic                  exp_neg;
    logic [15:0]           exp_dig;
    logic [2:0]            exp_cnt;
  } fmt_desc_t;

endpackage

// File: rtl/core/hff_front.sv
// hff_front: accepts a double, classifies and rounds it, converts the exponent to decimal
`timescale 1ns / 1ps

module hff_front #(
  parameter int MAX_PRECISION = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [63:0]       in_value_bits,
  input  logic signed [6:0] in_precision,
  input  logic [3:0]        in_format_flags,
  input  logic              q_full,
  output logic              q_push,
  output hff_pkg::fmt_desc_t q_data
);
  import hff_pkg::*;

  localparam logic [FRAC_CNT_W-1:0] MAXP = FRAC_CNT_W'(MAX_PRECISION);
  localparam logic [FRAC_CNT_W-1:0] DEFAULT_DIGITS = FRAC_CNT_W'(13);
  localparam logic [63:0] RND_BASE = 64'h4000_0000_0000_0000;
  localparam logic [63:0] RND_HALF = 64'h2000_0000_0000_0000;
  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;
  localparam logic [10:0] EXP_BIAS = 11'h3FF;

  front_state_t state_r, state_nxt;
  logic [63:0] bits_r;
  logic [6:0]  prec_r;
  logic [3:0]  flags_r;
  fmt_desc_t   desc_r, desc_nxt;
  logic [10:0] emag_r, emag_nxt;

  // classification
  logic                  prec_neg;
  logic [FRAC_CNT_W-1:0] prec_c;
  logic [63:0]           m0;
  logic [63:0]           rsum;
  logic [10:0]           exp_f;

  // decimal exponent
  logic        th;
  logic [9:0]  r1, hsub;
  logic [6:0]  r2, tsub;
  logic [3:0]  hund, tens, ones;
  logic [15:0] dig_all;
  logic [2:0]  ecnt, esh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_push) begin
      bits_r  <= in_value_bits;
      prec_r  <= in_precision;
      flags_r <= in_format_flags;
    end
    if (state_r == F_CLASS) begin
      desc_r <= desc_nxt;
      emag_r <= emag_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_full   = 1'b1;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_comb begin
    prec_neg = prec_r[6];
    if (prec_neg) begin
      prec_c = '0;
    end else if (prec_r[5:0] > MAXP) begin
      prec_c = MAXP;
    end else begin
      prec_c = prec_r[5:0];
    end
    exp_f = bits_r[62:52];
    m0    = {bits_r[51:0], 12'h000};
    rsum  = {2'b00, m0[63:2]} + RND_BASE + (RND_HALF >> {prec_c[3:0], 2'b00});

    desc_nxt          = '0;
    desc_nxt.kind     = K_NUM;
    desc_nxt.upper    = flags_r[3];
    desc_nxt.has_sign = bits_r[63] | flags_r[0] | flags_r[1];
    if (bits_r[63]) begin
      desc_nxt.sign_ch = CH_MINUS;
    end else if (flags_r[0]) begin
      desc_nxt.sign_ch = CH_PLUS;
    end else begin
      desc_nxt.sign_ch = CH_SPACE;
    end
    desc_nxt.point = flags_r[2];
    emag_nxt       = '0;

    if (bits_r == CANON_NAN) begin
      desc_nxt.kind     = K_NAN;
      desc_nxt.has_sign = 1'b0;
    end else if (bits_r[62:0] == '0) begin
      // zero: lead 0, zero digits up to the precision, exponent +0
      if (!prec_neg && prec_c != '0) begin
        desc_nxt.point = 1'b1;
        desc_nxt.nfrac = prec_c;
      end
    end else if (bits_r[62:0] == INF_MAG) begin
      desc_nxt.kind = K_INF;
    end else begin
      if (!prec_neg && prec_c < DEFAULT_DIGITS) begin
        desc_nxt.lead = rsum[63:62];
        desc_nxt.frac = {rsum[61:0], 2'b00};
      end else begin
        desc_nxt.lead = 2'd1;
        desc_nxt.frac = m0;
      end
      if (!prec_neg && prec_c != '0) begin
        desc_nxt.point = 1'b1;
        desc_nxt.nfrac = prec_c;
      end else if (prec_neg && m0 != '0) begin
        desc_nxt.point = 1'b1;
        desc_nxt.nfrac = DEFAULT_DIGITS;
      end
      if (exp_f < EXP_BIAS) begin
        desc_nxt.exp_neg = 1'b1;
        emag_nxt         = EXP_BIAS - exp_f;
      end else begin
        emag_nxt = exp_f - EXP_BIAS;
      end
    end
  end

  // binary to bcd of the exponent magnitude, at most 1024
  always_comb begin
    th   = emag_r >= 11'd1000;
    r1   = th ? 10'(emag_r - 11'd1000) : emag_r[9:0];
    hund = '0;
    hsub = '0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= 10'(k * 100)) begin
        hund = 4'(k);
        hsub = 10'(k * 100);
      end
    end
    r2   = 7'(r1 - hsub);
    tens = '0;
    tsub = '0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= 7'(k * 10)) begin
        tens = 4'(k);
        tsub = 7'(k * 10);
      end
    end
    ones    = 4'(r2 - tsub);
    dig_all = {3'b000, th, hund, tens, ones};
    if (th) begin
      ecnt = 3'd4;
    end else if (hund != '0) begin
      ecnt = 3'd3;
    end else if (tens != '0) begin
      ecnt = 3'd2;
    end else begin
      ecnt = 3'd1;
    end
    esh             = 3'd4 - ecnt;
    q_data          = desc_r;
    q_data.exp_dig  = dig_all << {esh, 2'b00};
    q_data.exp_cnt  = ecnt;
  end

endmodule

// File: rtl/core/hff_queue.sv
// hff_queue: short queue of classified values between front and back
`timescale 1ns / 1ps

module hff_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hff_pkg::fmt_desc_t push_data,
  output logic               full,
  input  logic               pop,
  output hff_pkg::fmt_desc_t head,
  output logic               empty
);
  import hff_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fmt_desc_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/hff_back.sv
// hff_back: spells one classified value out as text, one character per cycle unless the output stalls
`timescale 1ns / 1ps

module hff_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hff_pkg::fmt_desc_t q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [6:0]         out_character,
  output logic               out_last
);
  import hff_pkg::*;

  back_state_t           state_r, state_nxt;
  fmt_desc_t             cur_r, cur_nxt;
  logic [63:0]           frac_r, frac_nxt;
  logic [FRAC_CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [15:0]           edig_r, edig_nxt;
  logic [2:0]            ecnt_r, ecnt_nxt;
  logic [1:0]            widx_r, widx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  emit, fire, lst;
  logic [6:0]            ch;

  function automatic logic [6:0] letter(input logic [6:0] c, input logic upper);
    letter = upper ? (c & ~CH_CASE) : c;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) begin
      hex_char = CH_0 + {3'b000, nib};
    end else begin
      hex_char = letter(CH_A, upper) + {3'b000, nib} - 7'd10;
    end
  endfunction

  assign out_empty     = !out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign emit          = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    frac_r     <= frac_nxt;
    fcnt_r     <= fcnt_nxt;
    edig_r     <= edig_nxt;
    ecnt_r     <= ecnt_nxt;
    widx_r     <= widx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    edig_nxt  = edig_r;
    ecnt_nxt  = ecnt_r;
    widx_nxt  = widx_r;
    q_pop     = 1'b0;
    fire      = 1'b0;
    lst       = 1'b0;
    ch        = CH_0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_nxt  = q_data;
          frac_nxt = q_data.frac;
          fcnt_nxt = q_data.nfrac;
          edig_nxt = q_data.exp_dig;
          ecnt_nxt = q_data.exp_cnt;
          widx_nxt = '0;
          if (q_data.kind == K_NAN) begin
            state_nxt = B_WORD;
          end else if (q_data.has_sign) begin
            state_nxt = B_SIGN;
          end else if (q_data.kind == K_INF) begin
            state_nxt = B_WORD;
          end else begin
            state_nxt = B_ZERO;
          end
        end
      end
      B_WORD: begin
        if (emit) begin
          fire = 1'b1;
          case (widx_r)
            2'd0:    ch = (cur_r.kind == K_NAN) ? CH_N : CH_I;
            2'd1:    ch = (cur_r.kind == K_NAN) ? CH_A : CH_N;
            default: ch = (cur_r.kind == K_NAN) ? CH_N : CH_F;
          endcase
          ch       = letter(ch, cur_r.upper);
          widx_nxt = widx_r + 1'b1;
          if (widx_r == 2'd2) begin
            lst       = 1'b1;
            state_nxt = B_IDLE;
          end
        end
      end
      B_SIGN: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = cur_r.sign_ch;
          state_nxt = (cur_r.kind == K_INF) ? B_WORD : B_ZERO;
        end
      end
      B_ZERO: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = CH_0;
          state_nxt = B_X;
        end
      end
      B_X: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = letter(CH_X, cur_r.upper);
          state_nxt = B_LEAD;
        end
      end
      B_LEAD: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = hex_char({2'b00, cur_r.lead}, cur_r.upper);
          state_nxt = cur_r.point ? B_POINT : B_PEXP;
        end
      end
      B_POINT: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = CH_DOT;
          state_nxt = (fcnt_r != '0) ? B_FRAC : B_PEXP;
        end
      end
      B_FRAC: begin
        if (emit) begin
          fire     = 1'b1;
          ch       = hex_char(frac_r[63:60], cur_r.upper);
          frac_nxt = {frac_r[59:0], 4'h0};
          fcnt_nxt = fcnt_r - 1'b1;
          if (fcnt_r == FRAC_CNT_W'(1)) begin
            state_nxt = B_PEXP;
          end
        end
      end
      B_PEXP: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = letter(CH_P, cur_r.upper);
          state_nxt = B_ESIGN;
        end
      end
      B_ESIGN: begin
        if (emit) begin
          fire      = 1'b1;
          ch        = cur_r.exp_neg ? CH_MINUS : CH_PLUS;
          state_nxt = B_EDIG;
        end
      end
      B_EDIG: begin
        if (emit) begin
          fire     = 1'b1;
          ch       = CH_0 + {3'b000, edig_r[15:12]};
          edig_nxt = {edig_r[11:0], 4'h0};
          ecnt_nxt = ecnt_r - 1'b1;
          if (ecnt_r == 3'd1) begin
            lst       = 1'b1;
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = lst;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

`ifndef SYNTH
  a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FRAC) |-> (fcnt_r != '0))
    else $error("fraction phase with no digits left");

  a_exp_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EDIG) |-> (ecnt_r != 3'd0 && ecnt_r <= 3'd4))
    else $error("exponent digit count out of range");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != B_IDLE))
    else $error("value taken from queue but sequencer stayed idle");
`endif

endmodule

// File: rtl/core/hex_float_formatter_unit.sv
// hex_float_formatter_unit: top level of the printf hex float formatter
`timescale 1ns / 1ps

// usage
// - input word: raw 64-bit double, signed precision and four format flags;
//   taken on a rising edge with in_push high and in_full low
// - result word: one ascii character of the %a text with a last marker;
//   shown while out_empty is low, taken on a rising edge with out_pop high
// - the front classifies and rounds a value and turns its exponent into
//   decimal by capture, classify and hand-over to the queue, in that order
// - a two-deep queue separates the front from the character sequencer,
//   so the front keeps taking values while text is still being sent
// - the first character of a value passes the front registers, the queue
//   and the sequencer state on its way to the output register
// - the back sequencer writes one character per cycle while the receiver
//   keeps popping, and takes a new value only after the last character
//   of the current one; a value has 3 to 43 characters
// - a stalled receiver holds the output register, the sequencer waits,
//   the queue fills and the waiting front keeps in_full high
// - synchronous reset empties the queue and output register and idles
//   both state machines; no stored data needs clearing
module hex_float_formatter_unit #(
  parameter int MAX_PRECISION = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [63:0]       in_value_bits,
  input  logic signed [6:0] in_precision,
  input  logic [3:0]        in_format_flags,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [6:0]        out_character,
  output logic              out_last
);
  import hff_pkg::*;

  // front to queue
  logic      q_push, q_full;
  fmt_desc_t q_in;
  // queue to back
  logic      q_pop, q_empty;
  fmt_desc_t q_head;

  // classification, rounding and decimal exponent
  hff_front #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_value_bits  (in_value_bits),
    .in_precision   (in_precision),
    .in_format_flags(in_format_flags),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  // decoupling queue
  hff_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // character sequencer and output register
  hff_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_character(out_character),
    .out_last     (out_last)
  );

endmodule

// File: sim/hex_float_formatter_unit_tb.sv
// hex_float_formatter_unit_tb: self-checking testbench of the hex float formatter
`timescale 1ns / 1ps

// each double pushed in is spelled out here as the expected %a text, one
// character per word, and every popped word is checked against the oldest
// character still waiting; a directed set of corner values comes first,
// then a random mix weighted towards rounding, subnormals and odd precisions
module hex_float_formatter_unit_tb;
  import hff_pkg::*;

  localparam int MAX_PRECISION = 32;
  // cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 258;

  localparam logic [63:0] CANON_NAN  = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] INF_MAG    = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] ROUND_LEAD = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ROUND_HALF = 64'h2000_0000_0000_0000;

  // format flag bit positions
  localparam int FLAG_PLUS  = 0;
  localparam int FLAG_SPACE = 1;
  localparam int FLAG_POINT = 2;
  localparam int FLAG_UPPER = 3;

  typedef struct {
    logic [63:0]       bits;
    logic signed [6:0] prec;
    logic [3:0]        flags;
    bit                wait_drain;  // hold this word until all text is out
    int                gap_after;
  } value_word_t;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [63:0]       in_value_bits = '0;
  logic signed [6:0] in_precision = '0;
  logic [3:0]        in_format_flags = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [6:0]        out_character;
  logic              out_last;

  value_word_t value_words[$];    // words still to be pushed
  text_char_t  expected_text[$];  // characters still to be popped
  int          mismatch_count = 0;
  int          push_stall = 0;
  int          pop_stall = 0;
  int          pop_calm = 0;      // pops left in a no-stall stretch
  int          quiet_cycles = 0;

  hex_float_formatter_unit #(
    .MAX_PRECISION(MAX_PRECISION)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_value_bits(in_value_bits),
    .in_precision(in_precision),
    .in_format_flags(in_format_flags),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_character(out_character),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // expected text
  // ---------------------------------------------------------------------

  function automatic logic [6:0] letter(input logic [6:0] c, input logic up);
    return up ? (c & ~CH_CASE) : c;
  endfunction

  function automatic logic [6:0] hex_digit(input logic [3:0] nib, input logic up);
    if (nib < 4'd10) return CH_0 + 7'(nib);
    return (up ? CH_UC_A : CH_A) + 7'(nib) - 7'd10;
  endfunction

  // appends the %a text of one double to the expected characters
  task automatic spell_hex_float(input logic [63:0] bits, input logic signed [6:0] prec_in,
                                 input logic [3:0] flags);
    int          prec;
    int          ed;
    logic        up;
    logic [63:0] mag;
    logic [63:0] m;
    logic [6:0]  txt[$];
    logic [6:0]  dig[$];
    text_char_t  tc;

    prec = int'(prec_in);  // sign extends
    if (prec > MAX_PRECISION) prec = MAX_PRECISION;
    up = flags[FLAG_UPPER];

    if (bits == CANON_NAN) begin
      // only the one canonical pattern is nan, and it never has a sign
      txt.push_back(letter(CH_N, up));
      txt.push_back(letter(CH_A, up));
      txt.push_back(letter(CH_N, up));
    end else begin
      if (bits[63]) txt.push_back(CH_MINUS);
      else if (flags[FLAG_PLUS]) txt.push_back(CH_PLUS);
      else if (flags[FLAG_SPACE]) txt.push_back(CH_SPACE);
      mag = {1'b0, bits[62:0]};

      if (mag == '0) begin
        // zero: fraction padded with zeros to the precision
        txt.push_back(CH_0);
        txt.push_back(letter(CH_X, up));
        txt.push_back(CH_0);
        if (prec >= 1) begin
          txt.push_back(CH_DOT);
          for (int i = 0; i < prec; i++) txt.push_back(CH_0);
        end else if (flags[FLAG_POINT]) begin
          txt.push_back(CH_DOT);
        end
        txt.push_back(letter(CH_P, up));
        txt.push_back(CH_PLUS);
        txt.push_back(CH_0);
      end else if (mag == INF_MAG) begin
        txt.push_back(letter(CH_I, up));
        txt.push_back(letter(CH_N, up));
        txt.push_back(letter(CH_F, up));
      end else begin
        // normals, subnormals and non-canonical nans all take this path
        m  = mag << 12;
        ed = int'(mag[62:52]);
        ed = ed - 1023;
        txt.push_back(CH_0);
        txt.push_back(letter(CH_X, up));
        if (prec >= 0 && prec < 13) begin
          // round half up at the last digit; the carry can lift the lead to 2
          m = m >> 2;
          m = m + ROUND_LEAD + (ROUND_HALF >> (prec * 4));
          txt.push_back(hex_digit({2'b00, m[63:62]}, up));
          m = m << 2;
        end else begin
          txt.push_back(hex_digit(4'd1, up));
        end
        if (prec > 0 || (m != '0 && prec < 0)) begin
          if (prec < 0) prec = 13;
          txt.push_back(CH_DOT);
          for (int i = 0; i < prec; i++) begin
            txt.push_back(hex_digit(m[63:60], up));
            m = m << 4;
          end
        end else if (flags[FLAG_POINT]) begin
          txt.push_back(CH_DOT);
        end
        txt.push_back(letter(CH_P, up));
        if (ed >= 0) begin
          txt.push_back(CH_PLUS);
        end else begin
          txt.push_back(CH_MINUS);
          ed = -ed;
        end
        do begin
          dig.push_front(CH_0 + 7'(ed % 10));
          ed = ed / 10;
        end while (ed > 0);
        foreach (dig[i]) txt.push_back(dig[i]);
      end
    end

    foreach (txt[i]) begin
      tc.ch   = txt[i];
      tc.last = (i == txt.size() - 1);
      expected_text.push_back(tc);
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly back to back, often a few cycles, now and then a long pause
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(input logic [63:0] bits, input logic signed [6:0] prec,
                          input logic [3:0] flags, input bit drain, input int gap);
    value_word_t w;
    w.bits       = bits;
    w.prec       = prec;
    w.flags      = flags;
    w.wait_drain = drain;
    w.gap_after  = gap;
    value_words.push_back(w);
  endtask

  function automatic logic [63:0] random_value();
    logic        sgn;
    logic [51:0] frac;
    int          n;
    sgn  = 1'($urandom_range(0, 1));
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: return {sgn, 63'd0};
      1: return {sgn, INF_MAG[62:0]};
      2: begin
        if ($urandom_range(0, 1)) return CANON_NAN;
        if (frac == '0) frac = 52'd1;
        return {sgn, 11'h7ff, frac};
      end
      3: return {sgn, 11'h000, frac};
      4, 5: begin
        // exponent near zero, fraction often led by f digits to push carries
        n = $urandom_range(0, 13);
        if ($urandom_range(0, 1)) frac = frac | ~(52'hf_ffff_ffff_ffff >> (4 * n));
        return {sgn, 11'(1023 + $urandom_range(0, 8) - 4), frac};
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [6:0] random_precision();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 7'($urandom_range(0, 33) - 1);
    if (r < 85) return 7'($urandom_range(0, 13));
    return 7'($urandom_range(0, 127));  // anything the field holds
  endfunction

  // ---------------------------------------------------------------------
  // sender: pushes the queued words, pausing at random
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : push_side
    value_word_t w;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) spell_hex_float(in_value_bits, in_precision, in_format_flags);
      // the word on the ports may change once it is taken or was never offered
      if (!in_push || !in_full) begin
        if (push_stall > 0) begin
          in_push    <= 1'b0;
          push_stall <= push_stall - 1;
        end else if (value_words.size() == 0 ||
                     (value_words[0].wait_drain && expected_text.size() != 0)) begin
          in_push <= 1'b0;
        end else begin
          w = value_words.pop_front();
          in_push         <= 1'b1;
          in_value_bits   <= w.bits;
          in_precision    <= w.prec;
          in_format_flags <= w.flags;
          push_stall      <= w.gap_after;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: pops characters and checks them against the expected text
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : pop_side
    text_char_t want;
    int         stall_len;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (out_pop && !out_empty) begin
      if (expected_text.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got character %h last %b",
                 $time, out_character, out_last);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.ch) begin
          $display("%0t ns: character mismatch, expected %h, got %h",
                   $time, want.ch, out_character);
          mismatch_count = mismatch_count + 1;
        end
        if (out_last !== want.last) begin
          $display("%0t ns: last mismatch, expected %b, got %b",
                   $time, want.last, out_last);
          mismatch_count = mismatch_count + 1;
        end
      end
      // occasionally a long stretch of pops with no stalls at all
      if (pop_calm > 0) begin
        stall_len = 0;
        pop_calm <= pop_calm - 1;
      end else begin
        stall_len = idle_length();
        if ($urandom_range(0, 49) == 0) pop_calm <= 80;
      end
      if (stall_len == 0) begin
        out_pop <= 1'b1;
      end else begin
        out_pop   <= 1'b0;
        pop_stall <= stall_len - 1;
      end
    end else if (!out_pop) begin
      if (pop_stall == 0) out_pop <= 1'b1;
      else pop_stall <= pop_stall - 1;
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: gives up when no word moves on either side for too long
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: timeout, no word moved for %0d cycles, %0d characters outstanding",
                 $time, STALL_LIMIT, expected_text.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int burst_a;
    int burst_b;

    // directed corners: nan, inf, zeros, rounding carries, subnormals,
    // exponent extremes, precision saturation and default precision
    add_word(CANON_NAN,                 -1, 4'h0, 0, idle_length());
    add_word(CANON_NAN,                 5,  4'hf, 0, idle_length());
    add_word(64'h7ff8_0000_0000_0001,   -1, 4'h0, 0, idle_length());
    add_word(64'hfff8_0000_0000_0000,   3,  4'h8, 0, idle_length());
    add_word(64'h7ff0_0000_0000_0000,   -1, 4'h1, 0, idle_length());
    add_word(64'hfff0_0000_0000_0000,   -1, 4'h8, 0, idle_length());
    add_word(64'h7ff0_0000_0000_0000,   7,  4'h2, 0, idle_length());
    add_word(64'h0000_0000_0000_0000,   0,  4'h4, 0, idle_length());
    add_word(64'h0000_0000_0000_0000,   5,  4'h2, 0, idle_length());
    add_word(64'h8000_0000_0000_0000,   -1, 4'h0, 0, idle_length());
    add_word(64'h0000_0000_0000_0000,   40, 4'h9, 0, idle_length());
    add_word(64'h3ff0_0000_0000_0000,   -1, 4'h0, 0, idle_length());
    add_word(64'h3ff0_0000_0000_0000,   -1, 4'h4, 0, idle_length());
    add_word(64'h3ff8_0000_0000_0000,   0,  4'h0, 0, idle_length());
    add_word(64'h3fff_ffff_ffff_ffff,   12, 4'h8, 0, idle_length());
    add_word(64'h3fff_ffff_ffff_ffff,   13, 4'h0, 0, idle_length());
    add_word(64'h7fef_ffff_ffff_ffff,   -1, 4'h8, 0, idle_length());
    add_word(64'h0000_0000_0000_0001,   -1, 4'h0, 0, idle_length());
    add_word(64'h000f_ffff_ffff_ffff,   63, 4'hf, 0, idle_length());
    add_word(64'h0010_0000_0000_0000,   1,  4'h0, 0, idle_length());
    add_word(64'h4009_21fb_5444_2d18,   -64, 4'h8, 0, idle_length());
    add_word(64'hc009_21fb_5444_2d18,   33, 4'h3, 0, idle_length());
    add_word(64'h4009_21fb_5444_2d18,   32, 4'h6, 0, idle_length());

    // random part; two stretches with no sender gaps, and the first word
    // waits until all directed text has been popped
    burst_a = $urandom_range(40, 80);
    burst_b = $urandom_range(150, 200);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      add_word(random_value(), random_precision(), 4'($urandom_range(0, 15)),
               (i == 0) || ($urandom_range(0, 39) == 0),
               ((i >= burst_a && i < burst_a + 30) || (i >= burst_b && i < burst_b + 30))
                 ? 0 : idle_length());
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (value_words.size() != 0 || in_push) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    // room for any stray characters the block might still send
    repeat (60) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/hff_pkg.sv
rtl/core/hff_front.sv
rtl/core/hff_queue.sv
rtl/core/hff_back.sv
rtl/core/hex_float_formatter_unit.sv
sim/hex_float_formatter_unit_tb.sv
